@@ src/ute_pkg.sv @@
// ----------------------------------------------------------------------------
// ute_pkg
// shared types and constants of the undirected edge toggle table
// ----------------------------------------------------------------------------
package ute_pkg;

    localparam int MaxEdgesDefault   = 64;
    localparam int NodeIdBitsDefault = 8;
    localparam int StatusBits        = 3;

    // result status codes
    typedef enum logic [StatusBits-1:0] {
        STAT_CLEARED  = 3'd0,
        STAT_SELECTED = 3'd1,
        STAT_ADDED    = 3'd2,
        STAT_REMOVED  = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // outcome of a table scan
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

endpackage

@@ src/ute_if.sv @@
// ----------------------------------------------------------------------------
// ute_if
// valid/ready channels of the edge toggle table: click ids in, results out
// ----------------------------------------------------------------------------
interface ute_click_if #(
    parameter int NODE_ID_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [NODE_ID_BITS-1:0] node_id;

    modport source (output valid, output node_id, input ready);
    modport sink   (input valid, input node_id, output ready);
endinterface

interface ute_result_if #(
    parameter int NODE_ID_BITS = 8,
    parameter int COUNT_BITS   = 7
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic [NODE_ID_BITS-1:0] end_a;
    logic [NODE_ID_BITS-1:0] end_b;
    logic [COUNT_BITS-1:0]   edges_held;

    modport source (output valid, output status, output end_a, output end_b,
                    output edges_held, input ready);
    modport sink   (input valid, input status, input end_a, input end_b,
                    input edges_held, output ready);
endinterface

@@ src/ute_mem.sv @@
// ----------------------------------------------------------------------------
// ute_mem
// single-port-write, single-port-read edge memory, registered read data
// ----------------------------------------------------------------------------
module ute_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ute_scan.sv @@
// ----------------------------------------------------------------------------
// ute_scan
// tracks the matching slot and the lowest free slot while entries stream by
// ----------------------------------------------------------------------------
module ute_scan
    import ute_pkg::*;
#(
    parameter int NODE_ID_BITS = NodeIdBitsDefault,
    parameter int ADDR_BITS    = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      ent_vld,
    input  logic [ADDR_BITS-1:0]      ent_slot,
    input  logic [2*NODE_ID_BITS:0]   ent_word,
    input  logic [NODE_ID_BITS-1:0]   pair_a,
    input  logic [NODE_ID_BITS-1:0]   pair_b,
    output scan_flags_t               flags,
    output logic [ADDR_BITS-1:0]      slot
);

    logic                    ent_used;
    logic [NODE_ID_BITS-1:0] ent_first;
    logic [NODE_ID_BITS-1:0] ent_second;
    logic                    is_match;

    scan_flags_t            flags_reg;
    scan_flags_t            flags_next;
    logic [ADDR_BITS-1:0]   hit_slot_reg;
    logic [ADDR_BITS-1:0]   hit_slot_next;
    logic [ADDR_BITS-1:0]   free_slot_reg;
    logic [ADDR_BITS-1:0]   free_slot_next;

    assign ent_used   = ent_word[2*NODE_ID_BITS];
    assign ent_first  = ent_word[2*NODE_ID_BITS-1:NODE_ID_BITS];
    assign ent_second = ent_word[NODE_ID_BITS-1:0];

    // either order of the pair counts
    assign is_match = ent_used &&
                      (((ent_first == pair_a) && (ent_second == pair_b)) ||
                       ((ent_first == pair_b) && (ent_second == pair_a)));

    always_comb
    begin
        flags_next     = flags_reg;
        hit_slot_next  = hit_slot_reg;
        free_slot_next = free_slot_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (ent_vld)
        begin
            if (is_match && !flags_reg.hit)
            begin
                flags_next.hit = 1'b1;
                hit_slot_next  = ent_slot;
            end
            if (!ent_used && !flags_reg.free)
            begin
                flags_next.free = 1'b1;
                free_slot_next  = ent_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
    end

    assign flags = flags_reg;
    assign slot  = flags_reg.hit ? hit_slot_reg : free_slot_reg;

endmodule

@@ src/undirected_edge_toggle_table_unit.sv @@
// ----------------------------------------------------------------------------
// undirected_edge_toggle_table_unit
// pending-endpoint selector with a toggled table of undirected edges
// ----------------------------------------------------------------------------
// usage
//   click: one node id per transfer, 0 meaning nothing was hit
//   result: one transfer per click with status, the pair and the edge count
//   a clear click, or a click that only selects, passes from ST_IDLE to
//   ST_RESULT; a click that toggles a pair first scans the whole edge memory,
//   one entry per cycle through its single read port, in ST_SCAN and is
//   answered from ST_RESULT once the scan is done
//   click is taken only when no earlier click is still being worked on, so
//   the sequencer finishes each click before it takes the next one
//   the result register parts the two sides: a new click is taken while a
//   result still waits; its own result waits in the sequencer until the
//   result register frees up
//   after reset the edge memory is cleared one entry per cycle, all MAX_EDGES
//   entries, during which click.ready stays low
//   outside the reset clear, writes happen only when a result is loaded, never
//   during a scan, so a read and a write of the same entry cannot overlap
// ----------------------------------------------------------------------------
module undirected_edge_toggle_table_unit
    import ute_pkg::*;
#(
    parameter int MAX_EDGES    = MaxEdgesDefault,
    parameter int NODE_ID_BITS = NodeIdBitsDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    ute_click_if.sink    click,
    ute_result_if.source result
);

    localparam int AddrBits  = $clog2(MAX_EDGES);
    localparam int CountBits = $clog2(MAX_EDGES + 1);
    localparam int WordBits  = 2 * NODE_ID_BITS + 1;
    localparam logic [AddrBits-1:0] LastSlot = AddrBits'(MAX_EDGES - 1);

    state_t state_reg;
    state_t state_next;

    logic [NODE_ID_BITS-1:0] pending_reg;
    logic [NODE_ID_BITS-1:0] pending_next;
    logic [CountBits-1:0]    total_reg;
    logic [CountBits-1:0]    total_next;
    logic [AddrBits-1:0]     addr_reg;
    logic [AddrBits-1:0]     addr_next;
    logic                    issue_done_reg;
    logic                    issue_done_next;
    logic                    rd_vld_reg;
    logic                    rd_vld_next;
    logic [AddrBits-1:0]     rd_slot_reg;
    logic [AddrBits-1:0]     rd_slot_next;
    logic                    toggle_reg;
    logic                    toggle_next;

    // staged answer for clicks that do not toggle, and the clicked id
    logic [NODE_ID_BITS-1:0] cur_id_reg;
    logic [NODE_ID_BITS-1:0] cur_id_next;
    status_t                 stage_status_reg;
    status_t                 stage_status_next;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic [NODE_ID_BITS-1:0] out_a_reg;
    logic [NODE_ID_BITS-1:0] out_a_next;
    logic [NODE_ID_BITS-1:0] out_b_reg;
    logic [NODE_ID_BITS-1:0] out_b_next;
    logic [CountBits-1:0]    out_cnt_reg;
    logic [CountBits-1:0]    out_cnt_next;

    logic                    click_xfer;
    logic                    out_free;
    logic                    load_result;
    logic                    is_toggle;
    logic                    scan_start;

    logic                    mem_we;
    logic [AddrBits-1:0]     mem_waddr;
    logic [WordBits-1:0]     mem_wdata;
    logic                    mem_re;
    logic [WordBits-1:0]     mem_rdata;

    scan_flags_t             scan_flags;
    logic [AddrBits-1:0]     scan_slot;

    ute_mem #(
        .DEPTH (MAX_EDGES),
        .WIDTH (WordBits)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    ute_scan #(
        .NODE_ID_BITS (NODE_ID_BITS),
        .ADDR_BITS    (AddrBits)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .ent_vld  (rd_vld_reg),
        .ent_slot (rd_slot_reg),
        .ent_word (mem_rdata),
        .pair_a   (pending_reg),
        .pair_b   (cur_id_reg),
        .flags    (scan_flags),
        .slot     (scan_slot)
    );

    assign click.ready = (state_reg == ST_IDLE);
    assign click_xfer  = click.valid && click.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign load_result = (state_reg == ST_RESULT) && out_free;

    // a second, different id toggles the pair
    assign is_toggle = (click.node_id != '0) && (pending_reg != '0) &&
                       (pending_reg != click.node_id);
    assign scan_start = click_xfer && is_toggle;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LastSlot)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (click_xfer)
                begin
                    state_next = is_toggle ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (rd_vld_reg && (rd_slot_reg == LastSlot))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pending_next      = pending_reg;
        total_next        = total_reg;
        addr_next         = addr_reg;
        issue_done_next   = issue_done_reg;
        rd_vld_next       = 1'b0;
        rd_slot_next      = rd_slot_reg;
        toggle_next       = toggle_reg;
        cur_id_next       = cur_id_reg;
        stage_status_next = stage_status_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_status_next   = out_status_reg;
        out_a_next        = out_a_reg;
        out_b_next        = out_b_reg;
        out_cnt_next      = out_cnt_reg;
        mem_we            = 1'b0;
        mem_waddr         = addr_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // wipe one entry per cycle
                mem_we    = 1'b1;
                addr_next = addr_reg + AddrBits'(1);
            end
            ST_IDLE:
            begin
                if (click_xfer)
                begin
                    cur_id_next     = click.node_id;
                    toggle_next     = is_toggle;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    if (click.node_id == '0)
                    begin
                        pending_next      = '0;
                        stage_status_next = STAT_CLEARED;
                    end
                    else if (!is_toggle)
                    begin
                        pending_next      = click.node_id;
                        stage_status_next = STAT_SELECTED;
                    end
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, data back in the next cycle
                if (!issue_done_reg)
                begin
                    mem_re       = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_slot_next = addr_reg;
                    addr_next    = addr_reg + AddrBits'(1);
                    if (addr_reg == LastSlot)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
            end
            ST_RESULT:
            begin
                if (load_result)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = total_reg;
                    if (toggle_reg)
                    begin
                        out_a_next   = pending_reg;
                        out_b_next   = cur_id_reg;
                        pending_next = '0;
                        mem_waddr    = scan_slot;
                        if (scan_flags.hit)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = '0;
                            out_status_next = STAT_REMOVED;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - CountBits'(1);
                            end
                        end
                        else if (scan_flags.free)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = {1'b1, pending_reg, cur_id_reg};
                            out_status_next = STAT_ADDED;
                            total_next      = total_reg + CountBits'(1);
                        end
                        else
                        begin
                            out_status_next = STAT_FULL;
                        end
                        out_cnt_next = total_next;
                    end
                    else
                    begin
                        out_status_next = stage_status_reg;
                        out_a_next      = (stage_status_reg == STAT_SELECTED) ?
                                          cur_id_reg : '0;
                        out_b_next      = '0;
                    end
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            pending_reg    <= '0;
            total_reg      <= '0;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            toggle_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            total_reg      <= total_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            toggle_reg     <= toggle_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg      <= rd_slot_next;
        cur_id_reg       <= cur_id_next;
        stage_status_reg <= stage_status_next;
        out_status_reg   <= out_status_next;
        out_a_reg        <= out_a_next;
        out_b_reg        <= out_b_next;
        out_cnt_reg      <= out_cnt_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.end_a      = out_a_reg;
    assign result.end_b      = out_b_reg;
    assign result.edges_held = out_cnt_reg;

endmodule

@@ src/ute_checker.sv @@
// ----------------------------------------------------------------------------
// ute_checker
// port-level checks of the edge toggle table results
// ----------------------------------------------------------------------------
module ute_checker
    import ute_pkg::*;
#(
    parameter int MAX_EDGES    = MaxEdgesDefault,
    parameter int NODE_ID_BITS = NodeIdBitsDefault
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [2:0]                       status,
    input logic [NODE_ID_BITS-1:0]          end_a,
    input logic [NODE_ID_BITS-1:0]          end_b,
    input logic [$clog2(MAX_EDGES+1)-1:0]   edges_held
);

    // known status codes and a count within the table size
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == STAT_CLEARED) || (status == STAT_SELECTED) ||
                       (status == STAT_ADDED) || (status == STAT_REMOVED) ||
                       (status == STAT_FULL)) && (edges_held <= MAX_EDGES))
        else $error("bad status or edge count");

    // a cleared click carries no endpoints
    a_cleared_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_CLEARED) |-> (end_a == '0) && (end_b == '0))
        else $error("cleared result with endpoints");

    // a selection names one nonzero node
    a_selected_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_SELECTED) |-> (end_a != '0) && (end_b == '0))
        else $error("selection result with bad endpoints");

    // a toggle names two distinct nonzero nodes
    a_toggle_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == STAT_ADDED) || (status == STAT_REMOVED) ||
                      (status == STAT_FULL))
        |-> (end_a != '0) && (end_b != '0) && (end_a != end_b))
        else $error("toggle result with bad endpoints");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
                                    $stable(end_a) && $stable(end_b) &&
                                    $stable(edges_held))
        else $error("stalled result changed");

endmodule

bind undirected_edge_toggle_table_unit ute_checker #(
    .MAX_EDGES    (MAX_EDGES),
    .NODE_ID_BITS (NODE_ID_BITS)
) u_ute_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .end_a      (result.end_a),
    .end_b      (result.end_b),
    .edges_held (result.edges_held)
);
